[hw/rtl/dgf_pkg.sv]
// Package with types and constants of the digamma function unit.
package dgf_pkg;

    localparam int XW = 32;
    localparam int PW = 48;
    localparam int AW = 66;

    localparam logic signed [AW-1:0] C0 = -66'sd357913941;
    localparam logic signed [AW-1:0] C1 = 66'sd90592869;
    localparam logic signed [AW-1:0] C2 = -66'sd32537631;
    localparam logic signed [AW-1:0] C3 = 66'sd17895697;
    localparam logic signed [AW-1:0] C4 = -66'sd17043521;
    localparam logic signed [AW-1:0] C5 = 66'sd35791394;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [3:0] SHIFT_LIMIT = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RECIP,
        ST_R2,
        ST_HORNER,
        ST_LNSQ,
        ST_LNF,
        ST_HALF,
        ST_SUBR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] a;
        logic [63:0] b;
    } mdu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
        logic [63:0] p;
    } mdu_rsp_t;

    function automatic logic signed [AW-1:0] horner_coef(input logic [2:0] i);
        case (i)
            3'd0: horner_coef = C0;
            3'd1: horner_coef = C1;
            3'd2: horner_coef = C2;
            3'd3: horner_coef = C3;
            3'd4: horner_coef = C4;
            3'd5: horner_coef = C5;
            3'd6: horner_coef = C0;
            default: horner_coef = '0;
        endcase
    endfunction

endpackage

[hw/rtl/dgf_if.sv]
// Valid/ready channel interface carrying one word.
interface dgf_if #(
    parameter int W = 32
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/digamma_function_unit.sv]
// Top level of the digamma unit: sequencer around one shared multiply/divide unit.
// A word with x >= 10 needs 2 divides and 41 multiplies, and x below one needs 10 more divides;
// a zero argument skips the multiply/divide unit and goes straight to the result.
// A new word is accepted only after the previous one has been written to the output register.
// A finished result waits in the output register while the next word is taken and worked on.
// Reset: rst_n, asynchronous, active low, returns the sequencer to idle and empties the output.
module digamma_function_unit
    import dgf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dgf_if.sink   in_ch,
    dgf_if.source out_ch
);
    state_t state_reg, state_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] xs_reg, xs_next;
    logic [3:0]  inc_reg, inc_next;
    logic [3:0]  j_reg, j_next;
    logic [5:0]  i_reg, i_next;
    logic [31:0] r2_reg, r2_next;
    logic [32:0] m_reg, m_next;
    logic [31:0] f_reg, f_next;
    logic [4:0]  b_reg, b_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] hacc_reg, hacc_next;
    logic        busy_reg, busy_next;
    logic        start;
    mdu_req_t    req;
    mdu_rsp_t    rsp;
    logic        ovalid_reg, ovalid_next;
    logic [PW-1:0] psi_reg, psi_next;
    logic        inv_reg, inv_next;
    logic [AW-1:0] mag;
    logic [AW-1:0] rmag;
    logic [63:0] sq;
    logic [4:0]  top;
    logic [31:0] xin;
    logic [3:0]  inc_c;
    logic signed [5:0]  kexp;
    logic signed [38:0] klog;
    logic [63:0] fl;

    dgf_mdu u_mdu (.clk(clk), .rst_n(rst_n), .start(start), .req(req), .rsp(rsp));

    assign xin = in_ch.data;
    assign in_ch.ready = !busy_reg;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = {inv_reg, psi_reg};

    always_comb
    begin
        top = 5'd0;
        for (int k = 0; k < 32; k++)
        begin
            if (xs_reg[k])
            begin
                top = 5'(k);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg; xs_next = xs_reg; inc_next = inc_reg; j_next = j_reg;
        i_next = i_reg; r2_next = r2_reg; m_next = m_reg; f_next = f_reg;
        b_next = b_reg; neg_next = neg_reg; acc_next = acc_reg; hacc_next = hacc_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        ovalid_next = ovalid_reg; psi_next = psi_reg; inv_next = inv_reg;
        start = 1'b0;
        req = '{op: OP_NONE, a: '0, b: '0};
        mag = '0; rmag = '0; sq = '0; inc_c = '0; kexp = '0; klog = '0; fl = '0;
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    busy_next = 1'b1;
                    if (xin == 32'd0)
                    begin
                        zero_next = 1'b1;
                        acc_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        inc_c = (xin[31:16] < 16'(SHIFT_LIMIT))
                              ? SHIFT_LIMIT - xin[19:16] : 4'd0;
                        x_next = xin;
                        inc_next = inc_c;
                        xs_next = xin + {12'd0, inc_c, 16'd0};
                        start = 1'b1;
                        req = '{op: OP_DIV, a: 64'h1_0000_0000_0000
                                + {33'd0, xs_next[31:1]}, b: {32'd0, xs_next}};
                        state_next = ST_RECIP;
                    end
                end
            end
            ST_RECIP:
            begin
                if (rsp.done)
                begin
                    start = 1'b1;
                    req = '{op: OP_MUL, a: rsp.q, b: rsp.q};
                    state_next = ST_R2;
                end
            end
            ST_R2:
            begin
                if (rsp.done)
                begin
                    sq = rsp.p + 64'h8000_0000;
                    r2_next = sq[63:32];
                    hacc_next = C0;
                    i_next = 6'd1;
                    start = 1'b1;
                    req = '{op: OP_MUL, a: 64'd357913941, b: {32'd0, sq[63:32]}};
                    neg_next = 1'b1;
                    state_next = ST_HORNER;
                end
            end
            ST_HORNER:
            begin
                if (rsp.done)
                begin
                    sq = rsp.p + 64'h8000_0000;
                    mag = {34'd0, sq[63:32]};
                    acc_next = neg_reg ? -$signed(mag) : $signed(mag);
                    if (i_reg == 6'd7)
                    begin
                        b_next = top;
                        m_next = {1'b0, xs_reg << (5'd31 - top)};
                        f_next = '0;
                        i_next = 6'd31;
                        start = 1'b1;
                        req = '{op: OP_MUL, a: {32'd0, xs_reg << (5'd31 - top)},
                                b: {32'd0, xs_reg << (5'd31 - top)}};
                        state_next = ST_LNSQ;
                    end
                    else
                    begin
                        hacc_next = acc_next + horner_coef(i_reg[2:0]);
                        neg_next = hacc_next[AW-1];
                        rmag = hacc_next[AW-1] ? 66'(-hacc_next) : 66'(hacc_next);
                        i_next = i_reg + 6'd1;
                        start = 1'b1;
                        req = '{op: OP_MUL, a: rmag[63:0], b: {32'd0, r2_reg}};
                    end
                end
            end
            ST_LNSQ:
            begin
                // One squaring step of the bit-by-bit logarithm per multiply.
                if (rsp.done)
                begin
                    sq = rsp.p >> 31;
                    if (sq[32])
                    begin
                        m_next = {1'b0, sq[32:1]};
                        f_next = f_reg | (32'd1 << i_reg[4:0]);
                    end
                    else
                    begin
                        m_next = sq[32:0];
                    end
                    if (i_reg == 6'd0)
                    begin
                        start = 1'b1;
                        req = '{op: OP_MUL, a: {32'd0, f_next}, b: {32'd0, LN2_Q32}};
                        state_next = ST_LNF;
                    end
                    else
                    begin
                        i_next = i_reg - 6'd1;
                        start = 1'b1;
                        req = '{op: OP_MUL, a: {32'd0, m_next[31:0]},
                                b: {32'd0, m_next[31:0]}};
                    end
                end
            end
            ST_LNF:
            begin
                if (rsp.done)
                begin
                    fl = rsp.p + 64'h8000_0000;
                    kexp = $signed({1'b0, b_reg}) - 6'sd16;
                    klog = kexp * $signed({1'b0, LN2_Q32});
                    acc_next = acc_reg + AW'(klog) + $signed({34'd0, fl[63:32]});
                    start = 1'b1;
                    req = '{op: OP_DIV, a: 64'h8000_0000_0000 + {33'd0, xs_reg[31:1]},
                            b: {32'd0, xs_reg}};
                    state_next = ST_HALF;
                end
            end
            ST_HALF:
            begin
                if (rsp.done)
                begin
                    acc_next = acc_reg - $signed({2'b00, rsp.q});
                    j_next = 4'd0;
                    if (inc_reg != 4'd0)
                    begin
                        start = 1'b1;
                        req = '{op: OP_DIV, a: 64'h1_0000_0000_0000 + {33'd0, x_reg[31:1]},
                                b: {32'd0, x_reg}};
                        state_next = ST_SUBR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SUBR:
            begin
                if (rsp.done)
                begin
                    acc_next = acc_reg - $signed({2'b00, rsp.q});
                    j_next = j_reg + 4'd1;
                    if (j_next == inc_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        xs_next = x_reg + {12'd0, j_next, 16'd0};
                        start = 1'b1;
                        req = '{op: OP_DIV, a: 64'h1_0000_0000_0000 + {33'd0, xs_next[31:1]},
                                b: {32'd0, xs_next}};
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    mag = acc_reg[AW-1] ? 66'(-acc_reg) : 66'(acc_reg);
                    rmag = (mag + 66'd128) >> 8;
                    if (acc_reg[AW-1])
                    begin
                        psi_next = (rmag > 66'h8000_0000_0000) ? 48'h8000_0000_0000
                                 : 48'(-rmag);
                    end
                    else
                    begin
                        psi_next = (rmag > 66'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
                                 : rmag[47:0];
                    end
                    inv_next = zero_reg;
                    ovalid_next = 1'b1;
                    busy_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; xs_reg <= xs_next; inc_reg <= inc_next; j_reg <= j_next;
        i_reg <= i_next; r2_reg <= r2_next; m_reg <= m_next; f_reg <= f_next;
        b_reg <= b_next; neg_reg <= neg_next; acc_reg <= acc_next; hacc_reg <= hacc_next;
        zero_reg <= zero_next;
        psi_reg <= psi_next; inv_reg <= inv_next;
    end

    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready) else $error("input ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
        else $error("result changed while stalled");
    a_idle_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !busy_reg) else $error("busy in idle");
endmodule

[hw/rtl/dgf_mdu.sv]
// Shared multiply/divide unit: 64x32 multiply as two 32-bit partial products, radix-2 divide.
module dgf_mdu
    import dgf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  mdu_req_t req,
    output mdu_rsp_t rsp
);
    logic [6:0]  cnt_reg, cnt_next;
    op_t         op_reg, op_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [63:0] p_reg, p_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [63:0] part;

    // Multiply operand b is at most 32 bits; a is split into two 32-bit halves.
    always_comb
    begin
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, a_reg};
        part      = '0;
        if (start)
        begin
            op_next  = req.op;
            b_next   = req.b[31:0];
            p_next   = '0;
            if (req.op == OP_DIV)
            begin
                a_next   = req.b;
                quo_next = req.a;
                rem_next = '0;
                cnt_next = 7'd64;
            end
            else
            begin
                a_next   = req.a;
                cnt_next = 7'd2;
            end
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (op_reg == OP_DIV)
            begin
                if (!trial[64])
                begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[62:0], quo_reg[63]};
                    quo_next = {quo_reg[62:0], 1'b0};
                end
            end
            else
            begin
                if (cnt_reg == 7'd2)
                begin
                    part   = a_reg[31:0] * b_reg;
                    p_next = part;
                end
                else
                begin
                    part   = a_reg[63:32] * b_reg;
                    p_next = p_reg + {part[31:0], 32'd0};
                end
            end
            if (cnt_reg == 7'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            op_reg   <= OP_NONE;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        p_reg   <= p_next;
    end

    assign rsp.done = done_reg;
    assign rsp.q    = quo_reg;
    assign rsp.p    = p_reg;
endmodule

[bench/tb_top.sv]
// Self-checking testbench for the digamma function unit.
`timescale 1ns / 1ps

module tb_top;
    import dgf_pkg::*;

    localparam int STALL_LIMIT = 50000;

    typedef struct {
        logic [47:0] psi_value;
        logic        invalid;
    } psi_word_t;

    logic clk;
    logic rst_n;

    dgf_if #(.W(32)) in_ch ();
    dgf_if #(.W(49)) out_ch ();

    digamma_function_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    psi_word_t psi_expected[$];
    int        mismatches;
    int        idle_pct;
    int        stall_pct;
    int        hold_cycles;
    int        quiet_cycles;
    bit        finished;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Digamma predictor, all internal values in signed Q.32.
    function automatic logic [63:0] recip_q32(input logic [63:0] y);
        recip_q32 = ((64'd1 << 48) + (y >> 1)) / y;
    endfunction

    function automatic longint mul_rounded(input longint a, input logic [63:0] b);
        logic [63:0] mag;
        logic [63:0] prod;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = (mag * b + 64'd2147483648) >> 32;
        mul_rounded = (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint log_q32(input logic [63:0] xs);
        int          b;
        logic [63:0] m;
        logic [63:0] f;
        logic [63:0] frac;
        b = 31;
        f = '0;
        while (b > 0 && xs[b] == 1'b0)
            b--;
        m = xs << (31 - b);
        for (int i = 31; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                f[i] = 1'b1;
            end
        end
        frac = (f * 64'(LN2_Q32) + 64'd2147483648) >> 32;
        log_q32 = longint'(b - 16) * longint'(64'(LN2_Q32)) + longint'(frac);
    endfunction

    function automatic psi_word_t predict_psi(input logic [31:0] x);
        longint      coef[7];
        psi_word_t   res;
        logic [63:0] inc;
        logic [63:0] xs;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] mag;
        longint      acc;
        coef = '{-357913941, 90592869, -32537631, 17895697,
                 -17043521, 35791394, -357913941};
        res.invalid = 1'b0;
        res.psi_value = '0;
        if (x == 32'd0)
        begin
            res.invalid = 1'b1;
            return res;
        end
        inc = 0;
        if (x[31:16] < 16'(SHIFT_LIMIT))
            inc = 64'(SHIFT_LIMIT) - 64'(x[31:16]);
        xs = 64'(x) + (inc << 16);
        r  = recip_q32(xs);
        r2 = (r * r + 64'd2147483648) >> 32;
        acc = coef[0];
        for (int i = 1; i < 7; i++)
            acc = mul_rounded(acc, r2) + coef[i];
        acc = mul_rounded(acc, r2);
        acc += log_q32(xs);
        acc -= longint'(((64'd1 << 47) + (xs >> 1)) / xs);
        for (int j = 0; j < int'(inc); j++)
            acc -= longint'(recip_q32(64'(x) + (64'(j) << 16)));
        mag = (acc < 0) ? 64'(-acc) : 64'(acc);
        mag = (mag + 64'd128) >> 8;
        if (acc < 0)
            res.psi_value = (mag > 64'd140737488355328) ? 48'h8000_0000_0000
                                                         : 48'(-longint'(mag));
        else
            res.psi_value = (mag > 64'd140737488355327) ? 48'h7FFF_FFFF_FFFF
                                                         : 48'(mag);
        return res;
    endfunction

    // Sends one word; inputs move only at the falling edge.
    task automatic send_word(input logic [31:0] x);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = x;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        psi_expected.push_back(predict_psi(x));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (psi_expected.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] random_arg();
        case ($urandom_range(3))
            0: random_arg = $urandom_range(32'h000A_0000, 1);
            1: random_arg = {16'($urandom_range(15)), 16'($urandom)};
            2: random_arg = $urandom_range(32'h0000_FFFF, 1);
            default: random_arg = $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] args[$];
        args = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h000A_0000,
                 32'h0009_FFFF, 32'h0009_8000, 32'h0001_0000, 32'h0000_8000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h000B_0000, 32'h0000_FFFF,
                 32'h0005_5555, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h0002_0000, 32'h000A_0001};
        foreach (args[i])
            send_word(args[i]);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int ipct, input int spct);
        idle_pct  = ipct;
        stall_pct = spct;
        repeat (count)
            send_word(random_arg());
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 4000;
        repeat (6)
            send_word(random_arg());
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        psi_word_t exp_w;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (psi_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: psi=%h invalid=%b",
                             out_ch.data[47:0], out_ch.data[48]);
            end
            else
            begin
                exp_w = psi_expected.pop_front();
                if (out_ch.data[47:0] !== exp_w.psi_value
                    || out_ch.data[48] !== exp_w.invalid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: psi exp %h got %h, invalid exp %b got %b",
                                 exp_w.psi_value, out_ch.data[47:0],
                                 exp_w.invalid, out_ch.data[48]);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !finished)
        begin
            $display("digamma_function_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        mismatches   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        finished     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(110, 0, 0);
        test_backpressure();
        test_random(110, 50, 0);
        test_random(110, 0, 50);
        test_random(110, 23, 23);

        repeat (200) @(posedge clk);
        finished = 1'b1;
        if (mismatches == 0 && psi_expected.size() == 0)
            $display("digamma_function_unit verification clean");
        else
            $display("digamma_function_unit verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/dgf_pkg.sv
hw/rtl/dgf_if.sv
hw/rtl/dgf_mdu.sv
hw/rtl/digamma_function_unit.sv
bench/tb_top.sv
